// ===== rtl/hke_pkg.sv =====
package hke_pkg;

    localparam int KEY_DEPTH = 256;
    localparam int KEY_AW    = 8;
    localparam int NUM_W     = 35;
    localparam int DEN_W     = 19;
    localparam int MUL_W     = 33;

    localparam logic [1:0] CFG_KEY_COUNT    = 2'd0;
    localparam logic [1:0] CFG_VALUE_SCALE  = 2'd1;
    localparam logic [1:0] CFG_VALUE_OFFSET = 2'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    typedef struct packed {
        logic signed [15:0] frame;
        logic [15:0]        raw;
        logic signed [15:0] slope;
    } hke_key_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_CHECK,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_FETCH_L,
        ST_FETCH_R,
        ST_GOT_R,
        ST_MUL_V0,
        ST_CAP_V0,
        ST_MUL_V1,
        ST_CAP_V1,
        ST_DIV,
        ST_M_TH,
        ST_C_TH,
        ST_M_TS,
        ST_C_TS,
        ST_M_SD,
        ST_C_SD,
        ST_M_UM0,
        ST_C_UM0,
        ST_M_TM1,
        ST_C_TM1,
        ST_M_DU,
        ST_C_DU,
        ST_M_WT,
        ST_C_WT,
        ST_DONE
    } hke_state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } hke_div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } hke_div_rsp_t;

    function automatic logic signed [31:0] hke_sat32(input logic signed [65:0] x);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sh0_7FFF_FFFF;
        lo = -66'sh0_8000_0000;
        if (x > hi)
            return 32'sh7FFF_FFFF;
        else if (x < lo)
            return 32'sh8000_0000;
        else
            return x[31:0];
    endfunction

endpackage

// ===== rtl/hke_key_ram.sv =====
module hke_key_ram (
    input  logic                  clk,
    input  logic                  we,
    input  logic [7:0]            waddr,
    input  hke_pkg::hke_key_t     wdata,
    input  logic [7:0]            raddr,
    output hke_pkg::hke_key_t     rdata
);
    import hke_pkg::*;

    hke_key_t mem [KEY_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/hke_mul.sv =====
module hke_mul (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] prod_reg
);
    import hke_pkg::*;

    logic signed [65:0] prod_next;

    assign prod_next = 66'(a) * 66'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

// ===== rtl/hke_div.sv =====
module hke_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hke_pkg::hke_div_req_t req,
    output hke_pkg::hke_div_rsp_t rsp
);
    import hke_pkg::*;

    logic [DEN_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W+1:0] trial;

    // one restoring step per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[NUM_W-1]} - {2'b00, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_W+1])
            begin
                rem_next = trial[DEN_W:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== rtl/hermite_keyframe_curve_eval.sv =====
// load items: written into the key table in the cycle they are accepted; an evaluate item
// walks the key table one entry at a time over the one ram read port, then takes the divide
// (only when the query lies past the left key) and up to nine passes through the shared
// multiplier; a query at or beyond the end keys skips the walk and the divide
// throughput: one item at a time; input stall is high while an evaluate item is in work
// reset: asynchronous active low; key_count=1, scale=1.0, offset=0; key table not cleared
module hermite_keyframe_curve_eval (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                mode,
    input  logic [7:0]          key_index,
    input  logic signed [15:0]  key_frame,
    input  logic [15:0]         key_raw_value,
    input  logic signed [15:0]  key_slope,
    input  logic signed [18:0]  eval_frame,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  curve_value,
    output logic [7:0]          left_key,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import hke_pkg::*;

    // configuration
    logic [8:0]         key_count_reg;
    logic signed [31:0] value_scale_reg;
    logic signed [31:0] value_offset_reg;

    // control
    hke_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    // datapath registers
    logic signed [18:0] fq_reg, fq_next;
    logic [7:0]         last_reg, last_next;
    logic signed [15:0] first_f_reg, first_f_next;
    logic [7:0]         left_reg, left_next;
    logic [7:0]         scan_reg, scan_next;
    logic               single_reg, single_next;
    hke_key_t           key_l_reg, key_l_next;
    hke_key_t           key_r_reg, key_r_next;
    logic signed [31:0] v0_reg, v0_next;
    logic signed [31:0] v1_reg, v1_next;
    logic signed [19:0] d_reg, d_next;
    logic signed [17:0] t_reg, t_next;
    logic signed [18:0] shape_reg, shape_next;
    logic signed [37:0] acc_reg, acc_next;
    logic signed [43:0] tm_reg, tm_next;
    logic signed [27:0] tan_reg, tan_next;
    logic signed [29:0] w_reg, w_next;
    logic signed [31:0] res_reg, res_next;
    logic signed [31:0] curve_reg, curve_next;
    logic [7:0]         left_out_reg, left_out_next;

    // shared units
    hke_key_t           ram_rdata;
    hke_key_t           ram_wdata;
    logic [7:0]         ram_raddr;
    logic               ram_we;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    hke_div_req_t       div_req;
    hke_div_rsp_t       div_rsp;

    // combinational helpers
    logic [7:0]         last_calc;
    logic signed [18:0] q_wide;
    logic signed [15:0] q;
    logic signed [18:0] f0x8, f1x8, first8, last8;
    logic signed [19:0] d_calc, span_calc;
    logic signed [17:0] u;
    logic signed [18:0] h;
    logic signed [65:0] sh16, sh8, dec;
    logic signed [43:0] tsum;
    logic signed [37:0] wsum;
    logic [NUM_W-1:0]   quo;
    logic               out_free;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    assign ram_we    = accept && (mode == MODE_LOAD);
    assign ram_wdata = '{frame: key_frame, raw: key_raw_value, slope: key_slope};

    // clamp of the key count: zero acts as one, above the table size as the table size
    always_comb
    begin
        if (key_count_reg == 9'd0)
            last_calc = 8'd0;
        else if (key_count_reg > 9'(KEY_DEPTH))
            last_calc = 8'(KEY_DEPTH - 1);
        else
            last_calc = 8'(key_count_reg - 9'd1);
    end

    // query frame truncated toward zero into whole key-frame units
    assign q_wide = (fq_reg + (fq_reg[18] ? 19'sd7 : 19'sd0)) >>> 3;
    assign q      = q_wide[15:0];

    assign first8    = {first_f_reg, 3'b000};
    assign last8     = {ram_rdata.frame, 3'b000};
    assign f0x8      = {key_l_reg.frame, 3'b000};
    assign f1x8      = {key_r_reg.frame, 3'b000};
    assign d_calc    = 20'(fq_reg) - 20'(f0x8);
    assign span_calc = 20'(f1x8) - 20'(f0x8);

    // u = t - 1, h = 2t - 3, both in Q.16
    assign u = t_reg - 18'sd65536;
    assign h = 19'(t_reg) + 19'(t_reg) - 19'sd196608;

    assign sh16 = prod >>> 16;
    assign sh8  = prod >>> 8;
    assign dec  = prod + 66'(value_offset_reg);
    assign tsum = tm_reg + prod[43:0];
    assign wsum = acc_reg + sh16[37:0];
    assign quo  = div_rsp.quo;

    hke_key_ram u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (key_index),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hke_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    hke_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && mode == MODE_EVAL)
                    state_next = ST_RD_FIRST;
            end
            ST_RD_FIRST: state_next = ST_RD_LAST;
            ST_RD_LAST:  state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (fq_reg <= first8 || last8 <= fq_reg)
                    state_next = ST_FETCH_L;
                else
                    state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:  state_next = ST_SCAN_CMP;
            ST_SCAN_CMP:
            begin
                if (scan_reg == last_reg - 8'd1)
                    state_next = ST_FETCH_L;
                else
                    state_next = ST_SCAN_RD;
            end
            ST_FETCH_L:  state_next = ST_FETCH_R;
            ST_FETCH_R:  state_next = ST_GOT_R;
            ST_GOT_R:    state_next = ST_MUL_V0;
            ST_MUL_V0:   state_next = ST_CAP_V0;
            ST_CAP_V0:
            begin
                if (single_reg || d_calc == 20'sd0 || span_calc <= 20'sd0)
                    state_next = ST_DONE;
                else
                    state_next = ST_MUL_V1;
            end
            ST_MUL_V1:   state_next = ST_CAP_V1;
            ST_CAP_V1:
            begin
                if (d_reg > 20'sd0)
                    state_next = ST_DIV;
                else
                    state_next = ST_M_TH;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                    state_next = ST_M_TH;
            end
            ST_M_TH:     state_next = ST_C_TH;
            ST_C_TH:     state_next = ST_M_TS;
            ST_M_TS:     state_next = ST_C_TS;
            ST_C_TS:     state_next = ST_M_SD;
            ST_M_SD:     state_next = ST_C_SD;
            ST_C_SD:     state_next = ST_M_UM0;
            ST_M_UM0:    state_next = ST_C_UM0;
            ST_C_UM0:    state_next = ST_M_TM1;
            ST_M_TM1:    state_next = ST_C_TM1;
            ST_C_TM1:    state_next = ST_M_DU;
            ST_M_DU:     state_next = ST_C_DU;
            ST_C_DU:     state_next = ST_M_WT;
            ST_M_WT:     state_next = ST_C_WT;
            ST_C_WT:     state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: ram address, multiplier operands, divider start
    always_comb
    begin
        ram_raddr     = left_reg;
        mul_a         = '0;
        mul_b         = '0;
        div_req.start = 1'b0;
        div_req.num   = {d_reg[18:0], 16'd0};
        div_req.den   = span_calc[18:0];
        unique case (state_reg)
            ST_RD_FIRST: ram_raddr = 8'd0;
            ST_RD_LAST:  ram_raddr = last_reg;
            ST_SCAN_RD:  ram_raddr = scan_reg;
            ST_FETCH_L:  ram_raddr = left_reg;
            ST_FETCH_R:  ram_raddr = left_reg + 8'd1;
            ST_MUL_V0:
            begin
                mul_a = 33'(value_scale_reg);
                mul_b = 33'({1'b0, key_l_reg.raw});
            end
            ST_MUL_V1:
            begin
                mul_a = 33'(value_scale_reg);
                mul_b = 33'({1'b0, key_r_reg.raw});
            end
            ST_CAP_V1:   div_req.start = (d_reg > 20'sd0);
            ST_M_TH:
            begin
                mul_a = 33'(t_reg);
                mul_b = 33'(h);
            end
            ST_M_TS:
            begin
                mul_a = 33'(t_reg);
                mul_b = 33'(shape_reg);
            end
            ST_M_SD:
            begin
                mul_a = 33'(shape_reg);
                mul_b = 33'(v0_reg) - 33'(v1_reg);
            end
            ST_M_UM0:
            begin
                mul_a = 33'(u);
                mul_b = 33'($signed({key_l_reg.slope, 8'd0}));
            end
            ST_M_TM1:
            begin
                mul_a = 33'(t_reg);
                mul_b = 33'($signed({key_r_reg.slope, 8'd0}));
            end
            ST_M_DU:
            begin
                mul_a = 33'(d_reg);
                mul_b = 33'(u);
            end
            ST_M_WT:
            begin
                mul_a = 33'(w_reg);
                mul_b = 33'(tan_reg);
            end
            default:
            begin
                ram_raddr = left_reg;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        fq_next       = fq_reg;
        last_next     = last_reg;
        first_f_next  = first_f_reg;
        left_next     = left_reg;
        scan_next     = scan_reg;
        single_next   = single_reg;
        key_l_next    = key_l_reg;
        key_r_next    = key_r_reg;
        v0_next       = v0_reg;
        v1_next       = v1_reg;
        d_next        = d_reg;
        t_next        = t_reg;
        shape_next    = shape_reg;
        acc_next      = acc_reg;
        tm_next       = tm_reg;
        tan_next      = tan_reg;
        w_next        = w_reg;
        res_next      = res_reg;
        curve_next    = curve_reg;
        left_out_next = left_out_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                fq_next   = eval_frame;
                last_next = last_calc;
            end
            ST_RD_LAST:  first_f_next = ram_rdata.frame;
            ST_CHECK:
            begin
                scan_next = 8'd0;
                left_next = 8'd0;
                // at or before the first key, or at or after the last key: plain key value
                if (fq_reg <= first8)
                begin
                    single_next = 1'b1;
                end
                else if (last8 <= fq_reg)
                begin
                    single_next = 1'b1;
                    left_next   = last_reg;
                end
                else
                begin
                    single_next = 1'b0;
                end
            end
            ST_SCAN_CMP:
            begin
                if (ram_rdata.frame <= q)
                    left_next = scan_reg;
                scan_next = scan_reg + 8'd1;
            end
            ST_FETCH_R:  key_l_next = ram_rdata;
            ST_GOT_R:    key_r_next = ram_rdata;
            ST_CAP_V0:
            begin
                v0_next  = hke_sat32(dec);
                res_next = hke_sat32(dec);
                d_next   = d_calc;
            end
            ST_CAP_V1:
            begin
                v1_next = hke_sat32(dec);
                // a negative offset into the segment clamps t to zero
                t_next  = 18'sd0;
            end
            ST_DIV:
            begin
                if (quo > NUM_W'(65536))
                    t_next = 18'sd65536;
                else
                    t_next = 18'(quo[16:0]);
            end
            ST_C_TH:     shape_next = sh16[18:0];
            ST_C_TS:     shape_next = sh16[18:0];
            ST_C_SD:     acc_next   = 38'(v0_reg) + sh16[37:0];
            ST_C_UM0:    tm_next    = prod[43:0];
            ST_C_TM1:    tan_next   = 28'(tsum >>> 16);
            ST_C_DU:     w_next     = sh8[29:0];
            ST_C_WT:     res_next   = hke_sat32(66'(wsum));
            ST_DONE:
            begin
                if (out_free)
                begin
                    curve_next     = res_reg;
                    left_out_next  = left_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                fq_next = fq_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            key_count_reg    <= 9'd1;
            value_scale_reg  <= 32'sd65536;
            value_offset_reg <= 32'sd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY_COUNT:    key_count_reg    <= cfg_data[8:0];
                    CFG_VALUE_SCALE:  value_scale_reg  <= cfg_data;
                    CFG_VALUE_OFFSET: value_offset_reg <= cfg_data;
                    default:          key_count_reg    <= key_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fq_reg       <= fq_next;
        last_reg     <= last_next;
        first_f_reg  <= first_f_next;
        left_reg     <= left_next;
        scan_reg     <= scan_next;
        single_reg   <= single_next;
        key_l_reg    <= key_l_next;
        key_r_reg    <= key_r_next;
        v0_reg       <= v0_next;
        v1_reg       <= v1_next;
        d_reg        <= d_next;
        t_reg        <= t_next;
        shape_reg    <= shape_next;
        acc_reg      <= acc_next;
        tm_reg       <= tm_next;
        tan_reg      <= tan_next;
        w_reg        <= w_next;
        res_reg      <= res_next;
        curve_reg    <= curve_next;
        left_out_reg <= left_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign curve_value = curve_reg;
    assign left_key    = left_out_reg;

endmodule

// ===== verif/hermite_keyframe_curve_eval_test.sv =====
`timescale 1ns / 100ps

module hermite_keyframe_curve_eval_test;
    import hke_pkg::*;

    // one input item as queued for the driver
    typedef struct packed {
        logic               mode;
        logic [7:0]         key_index;
        logic signed [15:0] key_frame;
        logic [15:0]        key_raw_value;
        logic signed [15:0] key_slope;
        logic signed [18:0] eval_frame;
    } curve_item_t;

    typedef struct packed {
        logic signed [31:0] curve_value;
        logic [7:0]         left_key;
    } curve_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               mode;
    logic [7:0]         key_index;
    logic signed [15:0] key_frame;
    logic [15:0]        key_raw_value;
    logic signed [15:0] key_slope;
    logic signed [18:0] eval_frame;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] curve_value;
    logic [7:0]         left_key;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    hermite_keyframe_curve_eval dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .key_index(key_index), .key_frame(key_frame),
        .key_raw_value(key_raw_value), .key_slope(key_slope), .eval_frame(eval_frame),
        .out_valid(out_valid), .out_stall(out_stall),
        .curve_value(curve_value), .left_key(left_key),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state: shadow key table and registers
    logic signed [15:0] tbl_frame [KEY_DEPTH];
    logic [15:0]        tbl_raw   [KEY_DEPTH];
    logic signed [15:0] tbl_slope [KEY_DEPTH];
    logic [8:0]         cur_count;
    logic signed [31:0] cur_scale;
    logic signed [31:0] cur_offset;

    curve_item_t   pending_items [$];
    curve_result_t expected_curve [$];

    int  mismatches;
    int  cycle_count;
    bit  stop_driver;
    int  in_gap;
    int  out_gap;
    int  out_wait;

    // acceptance flags seen at the last rising edge
    logic in_stall_q;
    logic out_acc_q;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint floor_sh(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint key_value(int i);
        return clamp32(longint'(cur_scale) * longint'({1'b0, tbl_raw[i]})
                       + longint'(cur_offset));
    endfunction

    // curve evaluation at one query frame
    function automatic curve_result_t eval_curve(logic signed [18:0] qf);
        curve_result_t r;
        int n, last, lk;
        longint fq, q, val, f0, f1, d, span, v0, v1, m0, m1, t, u, h, shp, mix, w;
        n = cur_count;
        if (n < 1)
            n = 1;
        if (n > KEY_DEPTH)
            n = KEY_DEPTH;
        last = n - 1;
        fq = qf;
        if (fq <= longint'(tbl_frame[0]) * 8)
        begin
            val = key_value(0);
            lk = 0;
        end
        else if (longint'(tbl_frame[last]) * 8 <= fq)
        begin
            val = key_value(last);
            lk = last;
        end
        else
        begin
            q = fq / 8;     // toward zero
            lk = 0;
            for (int i = 0; i + 1 < n; i++)
                if (longint'(tbl_frame[i]) <= q)
                    lk = i;
            f0 = longint'(tbl_frame[lk]) * 8;
            f1 = longint'(tbl_frame[lk + 1]) * 8;
            d = fq - f0;
            span = f1 - f0;
            if (d == 0 || span <= 0)
                val = key_value(lk);
            else
            begin
                v0 = key_value(lk);
                v1 = key_value(lk + 1);
                m0 = longint'(tbl_slope[lk]) * 256;
                m1 = longint'(tbl_slope[lk + 1]) * 256;
                t = (d * 65536) / span;
                if (t < 0)
                    t = 0;
                if (t > 65536)
                    t = 65536;
                u = t - 65536;
                h = 2 * t - 3 * 65536;
                shp = floor_sh(t * h, 16);
                shp = floor_sh(t * shp, 16);
                mix = floor_sh(u * m0 + t * m1, 16);
                w = floor_sh(d * u, 8);
                val = clamp32(v0 + floor_sh(shp * (v0 - v1), 16) + floor_sh(w * mix, 16));
            end
        end
        r.curve_value = val[31:0];
        r.left_key = lk[7:0];
        return r;
    endfunction

    // driver: one item at a time from the queue, random gap before each
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall_q)
            begin
                in_valid <= 1'b0;
                in_gap <= $urandom_range(0, 18);
            end
            else if (!in_valid && !stop_driver && pending_items.size() > 0)
            begin
                if (in_gap > 0)
                    in_gap <= in_gap - 1;
                else
                begin
                    curve_item_t it;
                    it = pending_items.pop_front();
                    mode <= it.mode;
                    key_index <= it.key_index;
                    key_frame <= it.key_frame;
                    key_raw_value <= it.key_raw_value;
                    key_slope <= it.key_slope;
                    eval_frame <= it.eval_frame;
                    in_valid <= 1'b1;
                end
            end
            // receiver stall, drawn per result
            if (out_acc_q)
            begin
                out_wait = $urandom_range(0, 18);
                out_gap <= out_wait;
                out_stall <= (out_wait > 0);
            end
            else if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_stall <= (out_gap > 1);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // monitor: accepted input goes to the predictor, results are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            in_stall_q <= !(in_valid && !in_stall);
            out_acc_q <= out_valid && !out_stall;
            if (in_valid && !in_stall)
            begin
                if (mode == MODE_LOAD)
                begin
                    tbl_frame[key_index] = key_frame;
                    tbl_raw[key_index] = key_raw_value;
                    tbl_slope[key_index] = key_slope;
                end
                else
                    expected_curve.push_back(eval_curve(eval_frame));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_curve.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result value=%h left=%0d", curve_value, left_key);
                end
                else
                begin
                    curve_result_t exp_r;
                    exp_r = expected_curve.pop_front();
                    if (exp_r.curve_value !== curve_value || exp_r.left_key !== left_key)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp value=%h left=%0d got value=%h left=%0d",
                                     exp_r.curve_value, exp_r.left_key, curve_value, left_key);
                    end
                end
            end
            if (cycle_count > 3000000)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic push_load(int idx, int fr, int raw, int slope);
        curve_item_t it;
        it = '0;
        it.mode = MODE_LOAD;
        it.key_index = 8'(idx);
        it.key_frame = 16'(fr);
        it.key_raw_value = 16'(raw);
        it.key_slope = 16'(slope);
        it.eval_frame = 19'($urandom);
        pending_items.push_back(it);
    endtask

    task automatic push_eval(int qf);
        curve_item_t it;
        it = '0;
        it.mode = MODE_EVAL;
        it.key_index = 8'($urandom);
        it.key_frame = 16'($urandom);
        it.key_raw_value = 16'($urandom);
        it.key_slope = 16'($urandom);
        it.eval_frame = 19'(qf);
        pending_items.push_back(it);
    endtask

    // let every queued item go through and every result arrive
    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_curve.size() > 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_KEY_COUNT)
            cur_count = val[8:0];
        else if (idx == CFG_VALUE_SCALE)
            cur_scale = val;
        else
            cur_offset = val;
    endtask

    // non-decreasing table of n keys with random content
    task automatic load_table(int n, int spread);
        int fr;
        fr = -int'($urandom_range(0, 200)) * spread;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                fr = fr;        // repeated frame gives an empty segment
            else
                fr = fr + int'($urandom_range(1, spread));
            if (fr > 32767)
                fr = 32767;
            push_load(i, fr, int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)));
        end
    endtask

    function automatic int rand_query(int n);
        int lo, hi;
        lo = tbl_frame_q(0) * 8 - 300;
        hi = tbl_frame_q(n - 1) * 8 + 300;
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(0, 524287)) - 262144;
        if (hi <= lo)
            return lo;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // frames as they stand once the queue has drained
    function automatic int tbl_frame_q(int i);
        return tbl_frame[i];
    endfunction

    initial
    begin
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        mode = MODE_LOAD;
        key_index = '0;
        key_frame = '0;
        key_raw_value = '0;
        key_slope = '0;
        eval_frame = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_KEY_COUNT;
        cfg_data = '0;
        in_stall_q = 1'b1;
        out_acc_q = 1'b0;
        in_gap = 0;
        out_gap = 0;
        out_wait = 0;
        mismatches = 0;
        cycle_count = 0;
        stop_driver = 1'b0;
        cur_count = 1;
        cur_scale = 32'sd65536;
        cur_offset = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes of the fields, boundary cases, exact hit, segment interior
        push_load(0, -32768, 0, -32768);
        push_eval(-262144);
        push_eval(262143);
        push_load(1, 32767, 65535, 32767);
        push_load(255, 100, 65535, 0);
        drain();
        write_reg(CFG_KEY_COUNT, 32'd2);
        push_eval(-262144);
        push_eval(0);
        push_eval(-1);
        push_eval(262143);
        push_eval(32767 * 8 - 1);
        push_load(2, 10, 1000, 500);
        push_load(3, 10, 2000, -500);
        push_load(4, 40, 5000, 100);
        drain();
        write_reg(CFG_KEY_COUNT, 32'd5);
        push_eval(80);      // exact hit on a key
        push_eval(81);      // just after a key inside its segment
        push_eval(-5);      // negative query truncates toward zero
        push_eval(319);     // just before the last key
        drain();
        write_reg(CFG_VALUE_SCALE, 32'h7FFF_FFFF);
        write_reg(CFG_VALUE_OFFSET, 32'h7FFF_FFFF);
        push_eval(100);
        push_eval(-262144);
        drain();
        write_reg(CFG_VALUE_SCALE, 32'h8000_0000);
        write_reg(CFG_VALUE_OFFSET, 32'h8000_0000);
        push_eval(100);
        push_eval(262143);
        drain();
        write_reg(CFG_KEY_COUNT, 32'd0);     // acts as one key
        push_eval(12345);
        drain();

        // random phases: fresh table, settings, then queries
        for (int ph = 0; ph < 24; ph++)
        begin
            if (ph == 0)
                n = 256;
            else if (ph % 6 == 1)
                n = 2;
            else
                n = $urandom_range(2, 12);
            load_table(n, (ph % 3 == 0) ? 120 : int'($urandom_range(2, 40)));
            if (ph % 8 == 3)
                push_load(int'($urandom_range(0, n - 1)), int'($urandom), int'($urandom),
                          int'($urandom));
            drain();
            write_reg(CFG_KEY_COUNT, (ph == 5) ? 32'd256 : 32'(n));
            write_reg(CFG_VALUE_SCALE, (ph % 4 == 0) ? 32'sd65536 : $urandom);
            write_reg(CFG_VALUE_OFFSET, (ph % 5 == 0) ? 32'd0 : $urandom);
            for (int k = 0; k < ((n == 256) ? 10 : 23); k++)
                push_eval(rand_query(n));
            drain();
        end

        // results checked above; now decide
        if (mismatches == 0 && expected_curve.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hke_pkg.sv
rtl/hke_key_ram.sv
rtl/hke_mul.sv
rtl/hke_div.sv
rtl/hermite_keyframe_curve_eval.sv
verif/hermite_keyframe_curve_eval_test.sv
